// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the orbit generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed")

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond) \
    `ASSERT_CLK(label, !(cond))

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)

`endif

`endif

// ===== rtl/core/cosg_pkg.sv =====
// Shared types, constants and tables for the circular orbit setpoint generator.
`timescale 1ns / 1ps
`default_nettype none

package cosg_pkg;

    // Datapath widths
    localparam int DATA_W     = 32;
    localparam int RADIUS_W   = 31;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // CORDIC sizing
    localparam int CORDIC_STAGES = 24;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam int ATAN_N        = 32;
    localparam int ATAN_IDX_W    = $clog2(ATAN_N);
    localparam int GUARD_BITS    = 8;
    localparam int GAIN_SHIFT    = 23;
    localparam int PROD_W        = 2 * RADIUS_W;
    localparam int VEC_W         = 42;   // start vector < 2^39, CORDIC gain < 2
    localparam int ANG_W         = 34;   // residual angle plus sign and headroom

    localparam logic [RADIUS_W-1:0] GAIN_Q31     = 31'd1304065748;
    localparam logic [DATA_W-1:0]   HALF_TURN    = 32'h8000_0000;
    localparam logic [DATA_W-1:0]   QUARTER_TURN = 32'h4000_0000;

    // Request queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [DATA_W-1:0] ATAN_TURN [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_CENTRE = 2'd1,
        MODE_PAUSE  = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS   = 2'd0,
        REG_STEP     = 2'd1,
        REG_ALTITUDE = 2'd2
    } cfg_reg_t;

    // One setpoint job handed from front to back
    typedef struct packed {
        logic        [DATA_W-1:0] phase;
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
    } job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cosg_front.sv =====
// Front end: accepts requests, keeps centre/pause/phase state, queues setpoint jobs.
`timescale 1ns / 1ps
`default_nettype none

module cosg_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cosg_pkg::MODE_W-1:0]       mode,
    input  logic signed [cosg_pkg::DATA_W-1:0] target_x,
    input  logic signed [cosg_pkg::DATA_W-1:0] target_y,
    input  logic [cosg_pkg::DATA_W-1:0]       phase_step,
    input  cosg_pkg::q_status_t               q_status,
    output logic                              push,
    output cosg_pkg::job_t                    push_job
);
    import cosg_pkg::*;

    logic                     paused_reg, paused_next;
    logic                     centre_valid_reg, centre_valid_next;
    logic signed [DATA_W-1:0] cx_reg, cx_next;
    logic signed [DATA_W-1:0] cy_reg, cy_next;
    logic        [DATA_W-1:0] phase_reg, phase_next;
    logic                     accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Classify the request and update orbit state
    always_comb
    begin
        paused_next       = paused_reg;
        centre_valid_next = centre_valid_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        phase_next        = phase_reg;
        push              = 1'b0;
        if (accept)
        begin
            case (mode)
                MODE_TICK:
                begin
                    if (centre_valid_reg && !paused_reg)
                    begin
                        push       = 1'b1;
                        phase_next = phase_reg + phase_step;
                    end
                end
                MODE_CENTRE:
                begin
                    cx_next           = target_x;
                    cy_next           = target_y;
                    centre_valid_next = 1'b1;
                end
                MODE_PAUSE:
                begin
                    paused_next = !paused_reg;
                end
                default:
                begin
                    // unused code: dropped
                end
            endcase
        end
    end

    assign push_job.phase = phase_reg;
    assign push_job.cx    = cx_reg;
    assign push_job.cy    = cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg       <= 1'b0;
            centre_valid_reg <= 1'b0;
            cx_reg           <= '0;
            cy_reg           <= '0;
            phase_reg        <= '0;
        end
        else
        begin
            paused_reg       <= paused_next;
            centre_valid_reg <= centre_valid_next;
            cx_reg           <= cx_next;
            cy_reg           <= cy_next;
            phase_reg        <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cosg_queue.sv =====
// Short job queue between front end and CORDIC back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cosg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cosg_pkg::job_t      push_job,
    input  logic                pop,
    output cosg_pkg::job_t      head_job,
    output cosg_pkg::q_status_t status
);
    import cosg_pkg::*;

    job_t                 entries [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 full;
    logic                 empty;

    assign full          = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty         = (cnt_reg == '0);
    assign status.full   = full;
    assign status.empty  = empty;
    assign head_job      = entries[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_NEVER(a_q_no_overflow, push && full && !pop);
    `ASSERT_NEVER(a_q_no_underflow, pop && empty);
    `ASSERT_CLK(a_q_cnt_range, cnt_reg <= Q_CNT_W'(Q_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/core/cosg_back.sv =====
// Back end: iterative CORDIC that turns a queued job into one setpoint.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cosg_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cosg_pkg::q_status_t                q_status,
    input  cosg_pkg::job_t                     head_job,
    output logic                               pop,
    input  logic [cosg_pkg::RADIUS_W-1:0]      orbit_radius,
    input  logic signed [cosg_pkg::DATA_W-1:0] altitude,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [cosg_pkg::DATA_W-1:0] pos_x,
    output logic signed [cosg_pkg::DATA_W-1:0] pos_y,
    output logic signed [cosg_pkg::DATA_W-1:0] pos_z,
    output logic signed [cosg_pkg::DATA_W-1:0] heading
);
    import cosg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_INIT = 5'b00100,
        S_ROT  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    localparam logic [STAGE_W-1:0]      LAST_STAGE = STAGE_W'(CORDIC_STAGES - 1);
    localparam logic signed [VEC_W-1:0] RND_HALF   = VEC_W'(1) << (GUARD_BITS - 1);

    state_t                    state_reg, state_next;
    job_t                      job_reg;
    logic                      flip_reg;
    logic        [PROD_W-1:0]  prod_reg;
    logic signed [VEC_W-1:0]   x_reg, x_next;
    logic signed [VEC_W-1:0]   y_reg, y_next;
    logic signed [ANG_W-1:0]   z_reg, z_next;
    logic        [STAGE_W-1:0] idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg, heading_reg;

    logic        [DATA_W-1:0]  quad_sum;
    logic        [DATA_W-1:0]  folded;
    logic signed [VEC_W-1:0]   dx, dy;
    logic signed [ANG_W-1:0]   atan_step;
    logic signed [VEC_W-1:0]   x_sum, y_sum, x_shr, y_shr;
    logic        [DATA_W-1:0]  cos_term, sin_term;
    logic                      load_out;

    // Quadrant fold of the phase: flip when in [1/4, 3/4) turn
    assign quad_sum = job_reg.phase + QUARTER_TURN;
    assign folded   = job_reg.phase ^ {flip_reg, {(DATA_W - 1){1'b0}}};

    // One rotation step
    assign dx        = y_reg >>> idx_reg;
    assign dy        = x_reg >>> idx_reg;
    assign atan_step = signed'(ANG_W'(ATAN_TURN[ATAN_IDX_W'(idx_reg)]));

    // Drop guard bits with round-half-up, then undo the fold
    assign x_sum    = x_reg + RND_HALF;
    assign y_sum    = y_reg + RND_HALF;
    assign x_shr    = x_sum >>> GUARD_BITS;
    assign y_shr    = y_sum >>> GUARD_BITS;
    assign cos_term = flip_reg ? (DATA_W'(0) - x_shr[DATA_W-1:0]) : x_shr[DATA_W-1:0];
    assign sin_term = flip_reg ? (DATA_W'(0) - y_shr[DATA_W-1:0]) : y_shr[DATA_W-1:0];

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == S_IDLE) && !q_status.empty;

    // Sequencer and CORDIC iteration
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_INIT;
            end
            S_INIT:
            begin
                x_next     = signed'(VEC_W'(prod_reg >> GAIN_SHIFT));
                y_next     = '0;
                z_next     = ANG_W'(signed'(folded));
                idx_next   = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!z_reg[ANG_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_step;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_step;
                end
                if (idx_reg == LAST_STAGE)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (pop)
        begin
            job_reg <= head_job;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(orbit_radius) * PROD_W'(GAIN_Q31);
            flip_reg <= quad_sum[DATA_W-1];
        end
        if (load_out)
        begin
            pos_x_reg   <= job_reg.cx + cos_term;
            pos_y_reg   <= job_reg.cy + sin_term;
            pos_z_reg   <= altitude;
            heading_reg <= job_reg.phase + HALF_TURN;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign heading   = heading_reg;

    `ASSERT_CLK(a_rot_idx_range, (state_reg == S_ROT) |-> (idx_reg <= LAST_STAGE));
    `ASSERT_CLK(a_pop_starts_job, pop |=> (state_reg == S_MUL));
    `ASSERT_CLK(a_done_holds, (state_reg == S_DONE) && out_valid_reg && !out_ready |=> (state_reg == S_DONE));

endmodule

`default_nettype wire

// ===== rtl/core/circular_orbit_setpoint_generator_top.sv =====
// Top level of the circular orbit setpoint generator: config registers and front/queue/back.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    mode, target_x, target_y
//  out      out_valid / out_ready  pos_x, pos_y, pos_z, heading
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Centre, pause and unused-mode requests are handled in the front end alone.
// An emitting tick runs in the back end through S_MUL, S_INIT, the rotation steps and S_DONE,
// one at a time in the single shared CORDIC rotation unit; up to two ticks wait in the queue.
// Reset (rst_n low, async) restores default config and clears phase, pause and centre.
// in_ready drops only while the queue is full; the result register holds under out_ready low.
`timescale 1ns / 1ps
`default_nettype none

module circular_orbit_setpoint_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cosg_pkg::MODE_W-1:0]         mode,
    input  logic signed [cosg_pkg::DATA_W-1:0]  target_x,
    input  logic signed [cosg_pkg::DATA_W-1:0]  target_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cosg_pkg::DATA_W-1:0]  pos_x,
    output logic signed [cosg_pkg::DATA_W-1:0]  pos_y,
    output logic signed [cosg_pkg::DATA_W-1:0]  pos_z,
    output logic signed [cosg_pkg::DATA_W-1:0]  heading,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cosg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cosg_pkg::DATA_W-1:0]         cfg_data
);
    import cosg_pkg::*;

    logic        [RADIUS_W-1:0] radius_reg;
    logic        [DATA_W-1:0]   step_reg;
    logic signed [DATA_W-1:0]   altitude_reg;

    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;
    q_status_t q_status;

    assign cfg_ready = 1'b1;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= 31'd98304;
            step_reg     <= 32'd13671746;
            altitude_reg <= -32'sd327680;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIUS:   radius_reg   <= cfg_data[RADIUS_W-1:0];
                REG_STEP:     step_reg     <= cfg_data;
                REG_ALTITUDE: altitude_reg <= cfg_data;
                default:
                begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    cosg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .target_x   (target_x),
        .target_y   (target_y),
        .phase_step (step_reg),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    cosg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    cosg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_job     (head_job),
        .pop          (pop),
        .orbit_radius (radius_reg),
        .altitude     (altitude_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .heading      (heading)
    );

endmodule

`default_nettype wire

// ===== verif/tb_circular_orbit_setpoint_generator_top.sv =====
// Self-checking testbench for the circular orbit setpoint generator top level.
`timescale 1ns / 1ps

module tb_circular_orbit_setpoint_generator_top;

    import cosg_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = CORDIC_STAGES + 16;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam int IDLE_PCT      = 20;

    localparam logic [MODE_W-1:0]   MODE_UNUSED     = 2'd3;
    localparam logic [RADIUS_W-1:0] RADIUS_DEFAULT  = 31'd98304;
    localparam logic [DATA_W-1:0]   STEP_DEFAULT    = 32'd13671746;
    localparam logic [DATA_W-1:0]   ALT_DEFAULT     = 32'hFFFB_0000;

    // One setpoint as it leaves the block
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] h;
    } setpoint_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    // Directed stimulus: a request or a register write; code is mode or register index
    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        code;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              typed;
        setpoint_t         want;
    } stim_row_t;

    localparam setpoint_t NO_SP = '0;
    localparam int DIR_N = 30;

    localparam stim_row_t DIRECTED [DIR_N] = '{
        // tick before any centre: nothing
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        // quarter-turn steps land on every fold boundary
        '{ROW_WRITE, REG_STEP,     32'h4000_0000,  32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_CENTRE,  32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        // zero radius: position is the centre, heading is phase plus half turn
        '{ROW_WRITE, REG_RADIUS,   32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_WRITE, REG_STEP,     32'h00D0_9D42,  32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b1,
            '{32'h0, 32'h0, 32'hFFFB_0000, 32'h8000_0000}},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b1,
            '{32'h0, 32'h0, 32'hFFFB_0000, 32'h80D0_9D42}},
        '{ROW_ITEM,  MODE_CENTRE,  32'h7FFF_FFFF,  32'h8000_0000,  1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b1,
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFB_0000, 32'h81A1_3A84}},
        // paused tick and unused mode leave everything alone
        '{ROW_ITEM,  MODE_PAUSE,   32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_UNUSED,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, NO_SP},
        '{ROW_ITEM,  MODE_PAUSE,   32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_WRITE, REG_ALTITUDE, 32'h7FFF_FFFF,  32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b1,
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8271_D7C6}},
        // largest radius, position sums wrap
        '{ROW_WRITE, REG_RADIUS,   32'h7FFF_FFFF,  32'h0,          1'b0, NO_SP},
        '{ROW_WRITE, REG_ALTITUDE, 32'h8000_0000,  32'h0,          1'b0, NO_SP},
        '{ROW_WRITE, REG_STEP,     32'hFFFF_FFFF,  32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_CENTRE,  32'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_CENTRE,  32'h8000_0000,  32'h8000_0000,  1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_WRITE, REG_STEP,     32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP},
        '{ROW_ITEM,  MODE_TICK,    32'h0,          32'h0,          1'b0, NO_SP}
    };

    string FIELD_NAMES [4] = '{"pos_x", "pos_y", "pos_z", "heading"};

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [MODE_W-1:0]         mode;
    logic signed [DATA_W-1:0]  target_x;
    logic signed [DATA_W-1:0]  target_y;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  pos_x;
    logic signed [DATA_W-1:0]  pos_y;
    logic signed [DATA_W-1:0]  pos_z;
    logic signed [DATA_W-1:0]  heading;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [DATA_W-1:0]         cfg_data;

    // Predictor state: registers and orbit state
    logic [RADIUS_W-1:0] radius_reg = RADIUS_DEFAULT;
    logic [DATA_W-1:0]   step_reg   = STEP_DEFAULT;
    logic [DATA_W-1:0]   alt_reg    = ALT_DEFAULT;
    logic [DATA_W-1:0]   nco_phase  = '0;
    logic                orbit_paused = 1'b0;
    logic                centre_known = 1'b0;
    logic [DATA_W-1:0]   centre_x   = '0;
    logic [DATA_W-1:0]   centre_y   = '0;

    setpoint_t setpoint_q [$];
    int        mismatches   = 0;
    int        results_seen = 0;
    logic      steady_in    = 1'b0;

    circular_orbit_setpoint_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .target_x  (target_x),
        .target_y  (target_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .heading   (heading),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Setpoint for the current orbit state at phase ph (quadrant fold + CORDIC rotation)
    function automatic setpoint_t orbit_point(input logic [DATA_W-1:0] ph);
        logic [DATA_W-1:0] shifted;
        logic [DATA_W-1:0] folded;
        logic              flip;
        logic [63:0]       prod;
        longint            x;
        longint            y;
        longint            z;
        longint            dx;
        longint            dy;
        int                i;
        setpoint_t         sp;
        shifted = ph + QUARTER_TURN;
        flip    = shifted[DATA_W-1];
        folded  = flip ? ph - HALF_TURN : ph;
        z       = longint'($signed(folded));
        prod    = 64'(radius_reg) * 64'(GAIN_Q31);
        x       = longint'(prod >> GAIN_SHIFT);
        y       = 0;
        for (i = 0; i < CORDIC_STAGES && i < ATAN_N; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'd0, ATAN_TURN[i]});
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'd0, ATAN_TURN[i]});
            end
        end
        // drop guard bits, halves round up
        x = (x + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
        y = (y + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sp.x = centre_x + x[DATA_W-1:0];
        sp.y = centre_y + y[DATA_W-1:0];
        sp.z = alt_reg;
        sp.h = ph + HALF_TURN;
        return sp;
    endfunction

    // Offer one request, hold it until taken, then update the orbit state.
    // Entered and left at a rising edge.
    task automatic push_request(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] tx,
                                input logic [DATA_W-1:0] ty, input logic use_typed,
                                input setpoint_t typed_sp);
        while (!steady_in && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        target_x <= tx;
        target_y <= ty;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        case (m)
            MODE_CENTRE:
            begin
                centre_x     = tx;
                centre_y     = ty;
                centre_known = 1'b1;
            end
            MODE_PAUSE:
                orbit_paused = !orbit_paused;
            MODE_TICK:
                if (centre_known && !orbit_paused)
                begin
                    setpoint_q.push_back(use_typed ? typed_sp : orbit_point(nco_phase));
                    nco_phase = nco_phase + step_reg;
                end
            default:
                ;
        endcase
    endtask

    // Register write; the channel is left idle when the task returns
    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:   radius_reg = val[RADIUS_W-1:0];
            REG_STEP:     step_reg   = val;
            REG_ALTITUDE: alt_reg    = val;
            default:      ;
        endcase
        @(posedge clk);
    endtask

    // Let every outstanding setpoint out, then let the front end settle
    task automatic drain();
        in_valid <= 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure, one long hold-off, a stretch of steady ready, compare on accept
    initial
    begin : result_side
        int        hold_left;
        logic      hold_done;
        int        k;
        setpoint_t got;
        setpoint_t want;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (results_seen >= 450 && results_seen < 600)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            @(negedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = {pos_x, pos_y, pos_z, heading};
                if (setpoint_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: setpoint with none expected: %h", $time, got);
                end
                else
                begin
                    want = setpoint_q.pop_front();
                    for (k = 0; k < 4; k++)
                        if (got[127 - 32*k -: 32] !== want[127 - 32*k -: 32])
                        begin
                            mismatches++;
                            $display("%0t: %s expected %h actual %h", $time, FIELD_NAMES[k],
                                     want[127 - 32*k -: 32], got[127 - 32*k -: 32]);
                        end
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases under varied settings
    initial
    begin : stimulus
        int                k;
        int                p;
        int                counted;
        int                sel;
        logic [MODE_W-1:0] m;
        logic [DATA_W-1:0] tx;
        logic [DATA_W-1:0] ty;
        logic [DATA_W-1:0] rad;
        logic [DATA_W-1:0] stp;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= MODE_TICK;
        target_x  <= '0;
        target_y  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_RADIUS;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_N; k++)
        begin
            if (DIRECTED[k].kind == ROW_WRITE)
            begin
                drain();
                write_reg(cfg_reg_t'(DIRECTED[k].code), DIRECTED[k].a);
            end
            else
                push_request(DIRECTED[k].code, DIRECTED[k].a, DIRECTED[k].b,
                             DIRECTED[k].typed, DIRECTED[k].want);
        end

        for (p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            case (p)
                1:       rad = 32'h7FFF_FFFF;
                3:       rad = 32'h0;
                2, 5:    rad = $urandom() & 32'h7FFF_FFFF;
                default: rad = $urandom_range(0, 32'h0040_0000);
            endcase
            case (p)
                1:       stp = 32'hFFFF_FFFF;
                2:       stp = $urandom_range(0, 32'h0400_0000);
                4:       stp = 32'h0;
                default: stp = $urandom();
            endcase
            write_reg(REG_RADIUS, rad);
            write_reg(REG_STEP, stp);
            write_reg(REG_ALTITUDE, $urandom());
            steady_in = (p == 2);
            counted   = 0;
            while (counted < PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                // pause toggles are rare while running, likely while paused
                if (orbit_paused ? sel < 25 : sel < 3)
                    m = MODE_PAUSE;
                else if (sel < 15)
                    m = MODE_CENTRE;
                else if (sel < 19)
                    m = MODE_UNUSED;
                else
                    m = MODE_TICK;
                tx = $urandom_range(0, 1) ? $urandom()
                                          : $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                ty = $urandom_range(0, 1) ? $urandom()
                                          : $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                push_request(m, tx, ty, 1'b0, NO_SP);
                if (m != MODE_UNUSED)
                    counted++;
            end
        end
        steady_in = 1'b0;

        drain();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
